// File: src/sha512_pkg.sv
// shared types and constants for the sha-512 hash engine
`timescale 1ns / 1ps
package sha512_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned Rounds = 80;

  typedef logic [WordW-1:0] word_t;

  localparam word_t PadWord = 64'h8000000000000000;

  // control from the message sequencer to the round core
  typedef struct packed {
    logic  start;
  } core_ctrl_t;

  // status from the round core
  typedef struct packed {
    logic  busy;
    logic  done;
  } core_stat_t;

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    r = '0;
    case (idx)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      3'd7: r = 64'h5be0cd19137e2179;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] t);
    word_t r;
    r = '0;
    case (t)
      7'd0: r = 64'h428a2f98d728ae22;  7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f;  7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538;  7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b;  7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242;  7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/sha512_hash_engine_unit.sv
// sha-512 hash engine top level: padding sequencer, length counter and digest output
// a non-final word that completes a 1024-bit block starts a compression
// the round core runs one round per cycle, 80 rounds plus load and add per block
// a final word inserts padding words one per cycle and one or two compressions,
// then presents eight digest words, one per accepted output transaction
// reset (asynchronous, active low) restores initial hash values and clears the length
`timescale 1ns / 1ps
module sha512_hash_engine_unit import sha512_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [63:0] message_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        final_word_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] digest_word_o,
  output logic        digest_last_o
);

  typedef enum logic [2:0] {
    StIdle, StPush, StComp, StWait, StOut
  } state_e;

  state_e       state_q;
  logic [3:0]   pos_q;
  logic [127:0] len_q;
  logic         fin_q, pad80_q, lenhi_done_q, lenlo_done_q;
  logic [2:0]   out_q;
  logic         out_v_q;
  logic         init_q;

  logic         load;
  word_t        load_word;
  core_ctrl_t   ctrl;
  core_stat_t   stat;
  word_t        hword;

  logic         acc;
  logic [3:0]   vb;
  word_t        keep, padded;
  word_t        pad_word;
  logic         pad_last;

  assign acc = valid_i && ready_o;
  assign vb  = (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;

  always_comb begin
    keep   = (vb == 4'd0) ? '0 : ~(64'h0) << (7'd64 - {vb, 3'b000});
    padded = (message_word_i & keep) | (vb == 4'd8 ? 64'h0 : 64'h80 << (6'd56 - {vb[2:0], 3'b000}));
  end

  // padding word generator for the push state
  always_comb begin
    pad_word = '0;
    pad_last = 1'b0;
    if (pad80_q) pad_word = PadWord;
    else if (pos_q == 4'd14 && !lenhi_done_q) pad_word = len_q[127:64];
    else if (pos_q == 4'd15 && lenhi_done_q) begin
      pad_word = len_q[63:0];
      pad_last = 1'b1;
    end
  end

  assign ready_o = (state_q == StIdle);

  always_comb begin
    load = 1'b0;
    load_word = '0;
    if (acc) begin
      load = 1'b1;
      load_word = final_word_i ? padded : message_word_i;
    end else if (state_q == StPush) begin
      load = 1'b1;
      load_word = pad_word;
    end
  end

  assign ctrl.start = (state_q == StComp);

  sha512_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .load_i      (load),
    .load_word_i (load_word),
    .hash_init_i (init_q),
    .hash_sel_i  (out_q),
    .hash_word_o (hword),
    .stat_o      (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      pos_q        <= '0;
      len_q        <= '0;
      fin_q        <= 1'b0;
      pad80_q      <= 1'b0;
      lenhi_done_q <= 1'b0;
      lenlo_done_q <= 1'b0;
      out_q        <= '0;
      out_v_q      <= 1'b0;
      init_q       <= 1'b0;
    end else begin
      init_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            len_q <= len_q + (final_word_i ? 128'({vb, 3'b000}) : 128'd64);
            pos_q <= pos_q + 4'd1;
            fin_q <= final_word_i;
            pad80_q <= final_word_i && (vb == 4'd8);
            lenhi_done_q <= 1'b0;
            lenlo_done_q <= 1'b0;
            if (pos_q == 4'd15) state_q <= StComp;
            else if (final_word_i) state_q <= StPush;
          end
        end
        StPush: begin
          pos_q   <= pos_q + 4'd1;
          pad80_q <= 1'b0;
          if (!pad80_q && pos_q == 4'd14 && !lenhi_done_q) lenhi_done_q <= 1'b1;
          if (pad_last) lenlo_done_q <= 1'b1;
          if (pos_q == 4'd15) state_q <= StComp;
        end
        StComp: state_q <= StWait;
        StWait: begin
          if (!stat.busy) begin
            if (!fin_q) state_q <= StIdle;
            else if (lenlo_done_q) begin
              state_q <= StOut;
              out_q   <= '0;
              out_v_q <= 1'b1;
            end else state_q <= StPush;
          end
        end
        StOut: begin
          if (out_v_q && ready_i) begin
            out_q <= out_q + 3'd1;
            if (out_q == 3'd7) begin
              out_v_q <= 1'b0;
              init_q  <= 1'b1;
              len_q   <= '0;
              pos_q   <= '0;
              fin_q   <= 1'b0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign valid_o       = out_v_q;
  assign digest_word_o = hword;
  assign digest_last_o = (out_q == 3'd7);

  a_ready_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !ready_o) else $error("input taken during digest output");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && digest_last_o) |=> (ready_o && !valid_o))
    else $error("engine not idle after last digest word");
  a_core_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> !stat.busy) else $error("input accepted while compressing");

endmodule

// File: src/sha512_core.sv
// sha-512 round core: one round per cycle over a 16-word shift window
`timescale 1ns / 1ps
module sha512_core import sha512_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  logic       load_i,
  input  word_t      load_word_i,
  input  logic       hash_init_i,
  input  logic [2:0] hash_sel_i,
  output word_t      hash_word_o,
  output core_stat_t stat_o
);

  word_t       w_q [16];
  word_t       h_q [8];
  word_t       v_q [8];
  logic [6:0]  rnd_q;
  logic        busy_q, done_q;

  word_t w_new, w_cur, t1, t2, s0, s1, e0, e1;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  always_comb begin
    s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    w_cur = (rnd_q < 7'd16) ? w_q[0] : w_new;
    e1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
    e0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
    t1 = v_q[7] + e1 + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + w_cur;
    t2 = e0 + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // window: w_q[0] is oldest, new words enter at w_q[15]
  always_ff @(posedge clk_i) begin
    if (load_i || busy_q) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= load_i ? load_word_i : w_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= init_hash(3'(i));
        v_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      if (hash_init_i) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end else if (ctrl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end else if (busy_q) begin
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        if (rnd_q == 7'(Rounds - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          rnd_q  <= '0;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end else if (done_q) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  assign hash_word_o = h_q[hash_sel_i];
  assign stat_o.busy = busy_q | done_q;
  assign stat_o.done = done_q;

endmodule
